// ===== src/hts_pkg.sv =====
// Shared types, constants and helpers for the heightfield triangle sampler.
`timescale 1ns / 1ps
`default_nettype none

package hts_pkg;

    // Default sizes of the height store and the fixed-point format
    localparam int DEF_MAX_COLUMNS = 256;
    localparam int DEF_MAX_ROWS    = 256;
    localparam int DEF_FRAC_BITS   = 16;

    // Field widths
    localparam int COORD_W    = 32;
    localparam int HEIGHT_W   = 32;
    localparam int RECIP_W    = 17;
    localparam int COUNT_W    = 9;
    localparam int CELL_W     = 8;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 2 * CELL_W + HEIGHT_W + 2 * COORD_W;
    localparam int M_TDATA_W  = HEIGHT_W;

    // Register reset values
    localparam logic signed [COORD_W-1:0] ORIGIN_RESET = '0;
    localparam logic [RECIP_W-1:0]        RECIP_RESET  = 17'd65536;
    localparam logic [COUNT_W-1:0]        COUNT_RESET  = 9'd256;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_ORIGIN_X     = 3'd0,
        CFG_ORIGIN_Z     = 3'd1,
        CFG_RECIP_CELL   = 3'd2,
        CFG_GRID_COLUMNS = 3'd3,
        CFG_GRID_ROWS    = 3'd4
    } cfg_index_t;

    typedef enum logic {
        MODE_WRITE = 1'b0,
        MODE_QUERY = 1'b1
    } mode_t;

    // Grid index width; at least two bits so that a bank half-index exists
    function automatic int idx_width(input int n);
        int w;
        w = $clog2(n);
        return (w < 2) ? 2 : w;
    endfunction

endpackage

`default_nettype wire

// ===== src/hts_grid.sv =====
// Height store split in four banks by column and row parity; four corners per cycle.
`timescale 1ns / 1ps
`default_nettype none

module hts_grid import hts_pkg::*; #(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
    input  wire logic                                 aclk,
    input  wire logic                                 wr_en,
    input  wire logic [idx_width(MAX_COLUMNS)-1:0]    wr_col,
    input  wire logic [idx_width(MAX_ROWS)-1:0]       wr_row,
    input  wire logic [HEIGHT_W-1:0]                  wr_data,
    input  wire logic                                 rd_en,
    input  wire logic [idx_width(MAX_COLUMNS)-1:0]    rd_col,
    input  wire logic [idx_width(MAX_ROWS)-1:0]       rd_row,
    output logic signed [HEIGHT_W-1:0]                h00,
    output logic signed [HEIGHT_W-1:0]                h10,
    output logic signed [HEIGHT_W-1:0]                h01,
    output logic signed [HEIGHT_W-1:0]                h11
);

    localparam int CW         = idx_width(MAX_COLUMNS);
    localparam int RW         = idx_width(MAX_ROWS);
    localparam int AW         = (CW - 1) + (RW - 1);
    localparam int BANK_DEPTH = 1 << AW;
    localparam int NBANK      = 4;

    // bank index = {row parity, column parity}
    logic [HEIGHT_W-1:0] mem [NBANK][BANK_DEPTH];
    logic [HEIGHT_W-1:0] rd_data_reg [NBANK];
    logic                pcol_reg;
    logic                prow_reg;

    logic [CW-1:0]       col_p1;
    logic [RW-1:0]       row_p1;
    logic [AW-1:0]       raddr [NBANK];
    logic [AW-1:0]       waddr;
    logic [1:0]          wbank;

    // far corner is always one past the near one (clamp keeps it inside)
    assign col_p1 = rd_col + 1'b1;
    assign row_p1 = rd_row + 1'b1;

    always_comb begin
        for (int b = 0; b < NBANK; b++) begin
            raddr[b] = {
                (rd_row[0] == b[1]) ? rd_row[RW-1:1] : row_p1[RW-1:1],
                (rd_col[0] == b[0]) ? rd_col[CW-1:1] : col_p1[CW-1:1]
            };
        end
    end

    assign waddr = {wr_row[RW-1:1], wr_col[CW-1:1]};
    assign wbank = {wr_row[0], wr_col[0]};

    always_ff @(posedge aclk) begin
        for (int b = 0; b < NBANK; b++) begin
            if (wr_en && wbank == 2'(b)) begin
                mem[b][waddr] <= wr_data;
            end
            if (rd_en) begin
                rd_data_reg[b] <= mem[b][raddr[b]];
            end
        end
        if (rd_en) begin
            pcol_reg <= rd_col[0];
            prow_reg <= rd_row[0];
        end
    end

    // route banks back to corners
    always_comb begin
        h00 = prow_reg ? (pcol_reg ? rd_data_reg[3] : rd_data_reg[2])
                       : (pcol_reg ? rd_data_reg[1] : rd_data_reg[0]);
        h10 = prow_reg ? (pcol_reg ? rd_data_reg[2] : rd_data_reg[3])
                       : (pcol_reg ? rd_data_reg[0] : rd_data_reg[1]);
        h01 = prow_reg ? (pcol_reg ? rd_data_reg[1] : rd_data_reg[0])
                       : (pcol_reg ? rd_data_reg[3] : rd_data_reg[2]);
        h11 = prow_reg ? (pcol_reg ? rd_data_reg[0] : rd_data_reg[1])
                       : (pcol_reg ? rd_data_reg[2] : rd_data_reg[3]);
    end

endmodule

`default_nettype wire

// ===== src/heightfield_triangle_sampler_top.sv =====
// Top level of the heightfield triangle sampler: config, pipeline and output register.
//
//  Channel  Dir  Ports                          Content
//  -------  ---  -----------------------------  ----------------------------------------
//  input    in   s_tvalid s_tready s_tdata      write or query item, mode in s_tuser
//                s_tuser
//  result   out  m_tvalid m_tready m_tdata      interpolated height, one per query
//  config   in   cfg_we cfg_addr cfg_wdata      register write, no read-back
//
//  One transaction per cycle in both directions when nothing stalls. A query
//  passes every pipeline stage and the output register before m_tvalid;
//  two multiplier stages, the banked store read and the final add/saturate
//  are among them. A write item commits in stage 4 and returns nothing.
//  Reset (synchronous, aresetn low) clears valid bits and config registers;
//  the store is not cleared. Each stage holds while the one after it is full
//  and stalled; bubbles close up, so input keeps flowing behind a held result.
`timescale 1ns / 1ps
`default_nettype none

module heightfield_triangle_sampler_top import hts_pkg::*; #(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // input channel
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // s_tdata, low bit up: cell_col[7:0], cell_row[15:8], cell_height[47:16],
    //                      query_x[79:48], query_z[111:80]
    input  wire logic [S_TDATA_W-1:0]   s_tdata,
    // s_tuser: mode[0] (0 write, 1 query)
    input  wire logic [0:0]             s_tuser,
    // result channel
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // m_tdata, low bit up: height[31:0]
    output logic [M_TDATA_W-1:0]        m_tdata,
    // configuration
    input  wire logic                   cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int F      = FRAC_BITS;
    localparam int CW     = idx_width(MAX_COLUMNS);
    localparam int RW     = idx_width(MAX_ROWS);
    localparam int PXW    = CW + F;                    // clamped grid position x
    localparam int PZW    = RW + F;
    localparam int MULW   = COORD_W + RECIP_W;
    localparam int RAWW   = MULW - F;                  // scaled position before clamp
    localparam int CMPXW  = (RAWW > PXW) ? RAWW : PXW;
    localparam int CMPZW  = (RAWW > PZW) ? RAWW : PZW;
    localparam int DW     = HEIGHT_W + 1;              // coordinate / height difference
    localparam int PRODW  = DW + F + 1;                // slope term
    localparam int SUMW   = PRODW + 1;
    localparam int TOTW   = SUMW - F + 1;

    localparam logic signed [TOTW-1:0] SAT_MAX = TOTW'(32'sh7FFF_FFFF);
    localparam logic signed [TOTW-1:0] SAT_MIN = ~SAT_MAX;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] origin_x_reg;
    logic signed [COORD_W-1:0] origin_z_reg;
    logic [RECIP_W-1:0]        recip_cell_reg;
    logic [COUNT_W-1:0]        grid_columns_reg;
    logic [COUNT_W-1:0]        grid_rows_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg     <= ORIGIN_RESET;
            origin_z_reg     <= ORIGIN_RESET;
            recip_cell_reg   <= RECIP_RESET;
            grid_columns_reg <= COUNT_RESET;
            grid_rows_reg    <= COUNT_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_ORIGIN_X:     origin_x_reg     <= cfg_wdata[COORD_W-1:0];
                CFG_ORIGIN_Z:     origin_z_reg     <= cfg_wdata[COORD_W-1:0];
                CFG_RECIP_CELL:   recip_cell_reg   <= cfg_wdata[RECIP_W-1:0];
                CFG_GRID_COLUMNS: grid_columns_reg <= cfg_wdata[COUNT_W-1:0];
                CFG_GRID_ROWS:    grid_rows_reg    <= cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Grid size in use, clamped to [2, MAX]; upper position limit is one LSB
    // short of the last cell. Static while items flow is up to the user.
    logic [CW:0]     cols_use;
    logic [RW:0]     rows_use;
    logic [CW-1:0]   cols_m1;
    logic [RW-1:0]   rows_m1;
    logic [PXW-1:0]  hi_x;
    logic [PZW-1:0]  hi_z;

    always_comb begin
        if (grid_columns_reg < COUNT_W'(2)) begin
            cols_use = (CW+1)'(2);
        end else if (32'(grid_columns_reg) > 32'(MAX_COLUMNS)) begin
            cols_use = (CW+1)'(MAX_COLUMNS);
        end else begin
            cols_use = (CW+1)'(grid_columns_reg);
        end
        if (grid_rows_reg < COUNT_W'(2)) begin
            rows_use = (RW+1)'(2);
        end else if (32'(grid_rows_reg) > 32'(MAX_ROWS)) begin
            rows_use = (RW+1)'(MAX_ROWS);
        end else begin
            rows_use = (RW+1)'(grid_rows_reg);
        end
        cols_m1 = CW'(cols_use - 1'b1);
        rows_m1 = RW'(rows_use - 1'b1);
        hi_x    = {cols_m1, {F{1'b0}}} - 1'b1;
        hi_z    = {rows_m1, {F{1'b0}}} - 1'b1;
    end

    // ------------------------------------------------------------------
    // Stage handshake: a stage loads when empty or when its content moves on
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic en1, en2, en3, en4, en5, en6, en7, en_out;

    assign en_out   = !m_tvalid || m_tready;
    assign en7      = !v7_reg || en_out;
    assign en6      = !v6_reg || en7;
    assign en5      = !v5_reg || en6;
    assign en4      = !v4_reg || en5;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;

    // ------------------------------------------------------------------
    // Stage 1: unpack, subtract origin, check write address
    // ------------------------------------------------------------------
    logic [CELL_W-1:0]         in_col;
    logic [CELL_W-1:0]         in_row;
    logic [HEIGHT_W-1:0]       in_height;
    logic signed [COORD_W-1:0] in_qx;
    logic signed [COORD_W-1:0] in_qz;
    logic                      in_query;

    assign in_col    = s_tdata[CELL_W-1:0];
    assign in_row    = s_tdata[2*CELL_W-1:CELL_W];
    assign in_height = s_tdata[2*CELL_W+HEIGHT_W-1:2*CELL_W];
    assign in_qx     = s_tdata[2*CELL_W+HEIGHT_W+COORD_W-1:2*CELL_W+HEIGHT_W];
    assign in_qz     = s_tdata[S_TDATA_W-1:2*CELL_W+HEIGHT_W+COORD_W];
    assign in_query  = (s_tuser[0] == MODE_QUERY);

    logic                  q1_reg, w1_reg;
    logic [CW-1:0]         wcol1_reg;
    logic [RW-1:0]         wrow1_reg;
    logic [HEIGHT_W-1:0]   wdat1_reg;
    logic signed [DW-1:0]  dx1_reg, dz1_reg;
    logic signed [DW-1:0]  dx_next, dz_next;
    logic                  w_next;

    assign dx_next = DW'(in_qx) - DW'(origin_x_reg);
    assign dz_next = DW'(in_qz) - DW'(origin_z_reg);
    // writes outside the store are dropped
    assign w_next  = !in_query && (32'(in_col) < 32'(MAX_COLUMNS))
                               && (32'(in_row) < 32'(MAX_ROWS));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en1) begin
            v1_reg <= s_tvalid;
        end
        if (en1) begin
            q1_reg    <= in_query;
            w1_reg    <= w_next;
            wcol1_reg <= CW'(in_col);
            wrow1_reg <= RW'(in_row);
            wdat1_reg <= in_height;
            dx1_reg   <= dx_next;
            dz1_reg   <= dz_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: scale by reciprocal cell size; at or left of origin -> 0
    // ------------------------------------------------------------------
    logic [MULW-1:0]      mulx, mulz;
    logic [RAWW-1:0]      rawx_next, rawz_next;
    logic                 q2_reg, w2_reg;
    logic [CW-1:0]        wcol2_reg;
    logic [RW-1:0]        wrow2_reg;
    logic [HEIGHT_W-1:0]  wdat2_reg;
    logic [RAWW-1:0]      rawx2_reg, rawz2_reg;

    assign mulx      = dx1_reg[COORD_W-1:0] * recip_cell_reg;
    assign mulz      = dz1_reg[COORD_W-1:0] * recip_cell_reg;
    assign rawx_next = (!dx1_reg[DW-1] && dx1_reg != '0) ? mulx[MULW-1:F] : '0;
    assign rawz_next = (!dz1_reg[DW-1] && dz1_reg != '0) ? mulz[MULW-1:F] : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en2) begin
            v2_reg <= v1_reg;
        end
        if (en2) begin
            q2_reg    <= q1_reg;
            w2_reg    <= w1_reg;
            wcol2_reg <= wcol1_reg;
            wrow2_reg <= wrow1_reg;
            wdat2_reg <= wdat1_reg;
            rawx2_reg <= rawx_next;
            rawz2_reg <= rawz_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: clamp to the grid in use
    // ------------------------------------------------------------------
    logic [PXW-1:0]       px_next, px3_reg;
    logic [PZW-1:0]       pz_next, pz3_reg;
    logic                 q3_reg, w3_reg;
    logic [CW-1:0]        wcol3_reg;
    logic [RW-1:0]        wrow3_reg;
    logic [HEIGHT_W-1:0]  wdat3_reg;

    assign px_next = (CMPXW'(rawx2_reg) > CMPXW'(hi_x)) ? hi_x : PXW'(rawx2_reg);
    assign pz_next = (CMPZW'(rawz2_reg) > CMPZW'(hi_z)) ? hi_z : PZW'(rawz2_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en3) begin
            v3_reg <= v2_reg;
        end
        if (en3) begin
            q3_reg    <= q2_reg;
            w3_reg    <= w2_reg;
            wcol3_reg <= wcol2_reg;
            wrow3_reg <= wrow2_reg;
            wdat3_reg <= wdat2_reg;
            px3_reg   <= px_next;
            pz3_reg   <= pz_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: banked store; writes commit here in item order
    // ------------------------------------------------------------------
    logic signed [HEIGHT_W-1:0] c00, c10, c01, c11;
    logic [F-1:0]               tx4_reg, tz4_reg;

    hts_grid #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_grid (
        .aclk    (aclk),
        .wr_en   (en4 && v3_reg && w3_reg),
        .wr_col  (wcol3_reg),
        .wr_row  (wrow3_reg),
        .wr_data (wdat3_reg),
        .rd_en   (en4 && v3_reg && q3_reg),
        .rd_col  (px3_reg[PXW-1:F]),
        .rd_row  (pz3_reg[PZW-1:F]),
        .h00     (c00),
        .h10     (c10),
        .h01     (c01),
        .h11     (c11)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en4) begin
            v4_reg <= v3_reg && q3_reg;   // write items end here
        end
        if (en4) begin
            tx4_reg <= px3_reg[F-1:0];
            tz4_reg <= pz3_reg[F-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: pick triangle, form edge differences
    // ------------------------------------------------------------------
    logic signed [DW-1:0]       d1_next, d2_next, d1_5_reg, d2_5_reg;
    logic signed [HEIGHT_W-1:0] h00_5_reg;
    logic [F-1:0]               tx5_reg, tz5_reg;
    logic                       lower_tri;

    assign lower_tri = (tx4_reg >= tz4_reg);
    assign d1_next   = lower_tri ? (DW'(c10) - DW'(c00)) : (DW'(c11) - DW'(c01));
    assign d2_next   = lower_tri ? (DW'(c11) - DW'(c10)) : (DW'(c01) - DW'(c00));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en5) begin
            v5_reg <= v4_reg;
        end
        if (en5) begin
            d1_5_reg  <= d1_next;
            d2_5_reg  <= d2_next;
            h00_5_reg <= c00;
            tx5_reg   <= tx4_reg;
            tz5_reg   <= tz4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: slope terms
    // ------------------------------------------------------------------
    logic signed [PRODW-1:0]    p1_next, p2_next, p1_6_reg, p2_6_reg;
    logic signed [HEIGHT_W-1:0] h00_6_reg;

    assign p1_next = d1_5_reg * $signed({1'b0, tx5_reg});
    assign p2_next = d2_5_reg * $signed({1'b0, tz5_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (en6) begin
            v6_reg <= v5_reg;
        end
        if (en6) begin
            p1_6_reg  <= p1_next;
            p2_6_reg  <= p2_next;
            h00_6_reg <= h00_5_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: sum of slope terms
    // ------------------------------------------------------------------
    logic signed [SUMW-1:0]     s_next, s7_reg;
    logic signed [HEIGHT_W-1:0] h00_7_reg;

    assign s_next = SUMW'(p1_6_reg) + SUMW'(p2_6_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v7_reg <= 1'b0;
        end else if (en7) begin
            v7_reg <= v6_reg;
        end
        if (en7) begin
            s7_reg    <= s_next;
            h00_7_reg <= h00_6_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output register: floor by 2^F (arithmetic shift), add base, saturate
    // ------------------------------------------------------------------
    logic signed [TOTW-1:0]     total;
    logic [M_TDATA_W-1:0]       height_next;

    assign total = TOTW'($signed(s7_reg[SUMW-1:F])) + TOTW'(h00_7_reg);

    always_comb begin
        if (total > SAT_MAX) begin
            height_next = SAT_MAX[M_TDATA_W-1:0];
        end else if (total < SAT_MIN) begin
            height_next = SAT_MIN[M_TDATA_W-1:0];
        end else begin
            height_next = total[M_TDATA_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (en_out) begin
            m_tvalid <= v7_reg;
        end
        if (en_out) begin
            m_tdata <= height_next;
        end
    end

endmodule

`default_nettype wire

// ===== bench/tb_heightfield_triangle_sampler_top.sv =====
// Self-checking bench for the heightfield triangle sampler: height writes, interpolated queries.
`timescale 1ns / 1ps

module tb_heightfield_triangle_sampler_top;
    import hts_pkg::*;

    localparam int GRID_COLS      = DEF_MAX_COLUMNS;
    localparam int GRID_ROWS      = DEF_MAX_ROWS;
    localparam int FRAC           = DEF_FRAC_BITS;
    localparam longint unsigned FRAC_MASK = (64'd1 << FRAC) - 1;
    localparam longint HEIGHT_MAX = 64'sh7FFF_FFFF;
    localparam longint HEIGHT_MIN = -64'sh8000_0000;
    localparam int PHASE_ITEMS    = 58;
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 500;

    typedef struct {
        mode_t                      mode;
        logic [CELL_W-1:0]          col;
        logic [CELL_W-1:0]          row;
        logic signed [HEIGHT_W-1:0] height;
        logic signed [COORD_W-1:0]  qx;
        logic signed [COORD_W-1:0]  qz;
    } terrain_item_t;

    typedef struct {
        logic signed [COORD_W-1:0] org_x;
        logic signed [COORD_W-1:0] org_z;
        logic [RECIP_W-1:0]        recip;
        logic [COUNT_W-1:0]        cols;
        logic [COUNT_W-1:0]        rows;
    } grid_cfg_t;

    // Cell corners and in-cell fractions for one query
    typedef struct {
        int unsigned c0, c1, r0, r1;
        longint      tx, tz;
    } cell_pick_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [0:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    heightfield_triangle_sampler_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // Predictor state: height store, register copy, and what the stimulus has covered
    logic signed [HEIGHT_W-1:0] terrain [GRID_COLS*GRID_ROWS];
    bit                         cell_planned [GRID_COLS*GRID_ROWS];
    grid_cfg_t grid_cfg = '{org_x: ORIGIN_RESET, org_z: ORIGIN_RESET, recip: RECIP_RESET,
                            cols: COUNT_RESET, rows: COUNT_RESET};

    terrain_item_t              queued_items[$];
    logic signed [HEIGHT_W-1:0] pending_heights[$];

    int          error_count  = 0;
    int unsigned send_delay   = 0;
    int unsigned send_calm    = 0;
    int unsigned hold_delay   = 0;
    int unsigned take_calm    = 0;
    int unsigned quiet_cycles = 0;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic void flag(input string what);
        error_count++;
        if (error_count <= 10) $display("ERROR @%0t: %s", $time, what);
    endfunction

    // Idle cycles before the next transaction; occasional stretches with none at all
    function automatic int unsigned draw_idle(inout int unsigned calm);
        if (calm != 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) calm = $urandom_range(10, 40);
        return $urandom_range(0, 18);
    endfunction

    function automatic int unsigned clamp_count(input logic [COUNT_W-1:0] n,
                                                input int unsigned maxn);
        if (n < 2) return 2;
        if (n > maxn) return maxn;
        return n;
    endfunction

    // Unsigned grid position with FRAC fraction bits, clamped one LSB short of the last cell
    function automatic longint unsigned grid_position(input logic signed [COORD_W-1:0] q,
                                                      input logic signed [COORD_W-1:0] org,
                                                      input int unsigned n,
                                                      input logic [RECIP_W-1:0] recip);
        longint          d;
        longint unsigned p, hi;
        d  = longint'(q) - longint'(org);
        hi = (longint'(n) - 1) * (64'd1 << FRAC) - 1;
        p  = 0;
        if (d > 0) p = ($unsigned(d) * 64'(recip)) >> FRAC;
        return (p > hi) ? hi : p;
    endfunction

    function automatic cell_pick_t locate(input logic signed [COORD_W-1:0] qx,
                                          input logic signed [COORD_W-1:0] qz,
                                          input grid_cfg_t c);
        cell_pick_t      k;
        longint unsigned px, pz;
        int unsigned     nc, nr;
        nc   = clamp_count(c.cols, GRID_COLS);
        nr   = clamp_count(c.rows, GRID_ROWS);
        px   = grid_position(qx, c.org_x, nc, c.recip);
        pz   = grid_position(qz, c.org_z, nr, c.recip);
        k.c0 = px >> FRAC;
        k.r0 = pz >> FRAC;
        k.tx = px & FRAC_MASK;
        k.tz = pz & FRAC_MASK;
        k.c1 = (k.c0 + 1 < nc - 1) ? k.c0 + 1 : nc - 1;
        k.r1 = (k.r0 + 1 < nr - 1) ? k.r0 + 1 : nr - 1;
        return k;
    endfunction

    // Triangle interpolation, lower triangle when tx >= tz; slope sum floored, then saturated
    function automatic logic signed [HEIGHT_W-1:0] interpolate_height(input terrain_item_t it);
        cell_pick_t k;
        longint     h00, h10, h01, h11, slope, total;
        k   = locate(it.qx, it.qz, grid_cfg);
        h00 = terrain[k.r0 * GRID_COLS + k.c0];
        h10 = terrain[k.r0 * GRID_COLS + k.c1];
        h01 = terrain[k.r1 * GRID_COLS + k.c0];
        h11 = terrain[k.r1 * GRID_COLS + k.c1];
        if (k.tx >= k.tz) slope = (h10 - h00) * k.tx + (h11 - h10) * k.tz;
        else              slope = (h11 - h01) * k.tx + (h01 - h00) * k.tz;
        total = h00 + (slope >>> FRAC);
        if (total > HEIGHT_MAX) total = HEIGHT_MAX;
        if (total < HEIGHT_MIN) total = HEIGHT_MIN;
        return total[HEIGHT_W-1:0];
    endfunction

    // Accepted transaction: update the store copy or queue the expected height
    function automatic void absorb_item(input terrain_item_t it);
        if (it.mode == MODE_WRITE) terrain[it.row * GRID_COLS + it.col] = it.height;
        else pending_heights.push_back(interpolate_height(it));
    endfunction

    function automatic logic signed [HEIGHT_W-1:0] pick_height();
        case ($urandom_range(0, 7))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2, 3:    return 32'($urandom_range(0, 1 << 22)) - 32'(1 << 21);
            default: return $urandom;
        endcase
    endfunction

    function automatic void add_write(input int unsigned col, input int unsigned row,
                                      input logic signed [HEIGHT_W-1:0] h);
        terrain_item_t it;
        it.mode   = MODE_WRITE;
        it.col    = col;
        it.row    = row;
        it.height = h;
        it.qx     = $urandom;   // don't-care fields still toggle
        it.qz     = $urandom;
        queued_items.push_back(it);
        cell_planned[row * GRID_COLS + col] = 1'b1;
    endfunction

    function automatic void cover_cell(input int unsigned col, input int unsigned row);
        if (!cell_planned[row * GRID_COLS + col]) add_write(col, row, pick_height());
    endfunction

    // A query never reads a never-written entry: missing corners are written first
    function automatic void add_query(input logic signed [COORD_W-1:0] qx,
                                      input logic signed [COORD_W-1:0] qz);
        cell_pick_t    k;
        terrain_item_t it;
        k = locate(qx, qz, grid_cfg);
        cover_cell(k.c0, k.r0);
        cover_cell(k.c1, k.r0);
        cover_cell(k.c0, k.r1);
        cover_cell(k.c1, k.r1);
        it.mode   = MODE_QUERY;
        it.col    = $urandom_range(0, 255);
        it.row    = $urandom_range(0, 255);
        it.height = $urandom;
        it.qx     = qx;
        it.qz     = qz;
        queued_items.push_back(it);
    endfunction

    // Coordinate mostly inside the grid, some before the origin, past the far edge or anywhere
    function automatic logic signed [COORD_W-1:0] aim_coord(input logic signed [COORD_W-1:0] org,
                                                            input int unsigned n,
                                                            input logic [RECIP_W-1:0] recip);
        longint unsigned span;
        longint          base;
        base = longint'(org);
        span = (recip == 0) ? 64'hFFFF_FFFF : (64'(n - 1) << 32) / 64'(recip);
        if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return 32'(base - longint'($urandom_range(1, 1 << 18)));
            2:       return 32'(base + longint'(span) + longint'($urandom_range(0, 1 << 20)));
            3:       return 32'(base + longint'(span) - longint'($urandom_range(0, 3)));
            4:       return 32'(base + longint'(span * $urandom_range(0, n - 1) / (n - 1)));
            default: return 32'(base + longint'({$urandom, $urandom} % (span + 1)));
        endcase
    endfunction

    function automatic void fill_phase(input int n);
        int unsigned nc, nr;
        nc = clamp_count(grid_cfg.cols, GRID_COLS);
        nr = clamp_count(grid_cfg.rows, GRID_ROWS);
        while (queued_items.size() < n) begin
            case ($urandom_range(0, 9))
                0:       add_write($urandom_range(0, 255), $urandom_range(0, 255), pick_height());
                1, 2:    add_write($urandom_range(0, nc - 1), $urandom_range(0, nr - 1),
                                   pick_height());
                default: add_query(aim_coord(grid_cfg.org_x, nc, grid_cfg.recip),
                                   aim_coord(grid_cfg.org_z, nr, grid_cfg.recip));
            endcase
        end
    endfunction

    function automatic grid_cfg_t grid_setting(input logic [31:0] ox, input logic [31:0] oz,
                                               input int unsigned recip,
                                               input int unsigned cols,
                                               input int unsigned rows);
        grid_cfg_t c;
        c.org_x = ox;
        c.org_z = oz;
        c.recip = recip;
        c.cols  = cols;
        c.rows  = rows;
        return c;
    endfunction

    // Write all five registers on consecutive edges; block must be idle
    task automatic program_grid(input grid_cfg_t c);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_ORIGIN_X;
        cfg_wdata <= c.org_x;
        @(posedge aclk);
        cfg_addr  <= CFG_ORIGIN_Z;
        cfg_wdata <= c.org_z;
        @(posedge aclk);
        cfg_addr  <= CFG_RECIP_CELL;
        cfg_wdata <= 32'(c.recip);
        @(posedge aclk);
        cfg_addr  <= CFG_GRID_COLUMNS;
        cfg_wdata <= 32'(c.cols);
        @(posedge aclk);
        cfg_addr  <= CFG_GRID_ROWS;
        cfg_wdata <= 32'(c.rows);
        @(posedge aclk);
        cfg_we    <= 1'b0;
        grid_cfg   = c;
    endtask

    // Wait for all transactions sent and answered, then let writes commit
    task automatic settle();
        do @(posedge aclk);
        while (queued_items.size() != 0 || pending_heights.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Source side: present the queue head after a random gap, hold it until taken
    always @(posedge aclk) begin : driver
        int unsigned w;
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            send_delay <= draw_idle(send_calm);
        end else if (!s_tvalid || s_tready) begin
            w = send_delay;
            if (s_tvalid) begin
                absorb_item(queued_items.pop_front());
                w = draw_idle(send_calm);
            end
            if (w == 0 && queued_items.size() != 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {queued_items[0].qz, queued_items[0].qx, queued_items[0].height,
                             queued_items[0].row, queued_items[0].col};
                s_tuser  <= queued_items[0].mode;
            end else begin
                s_tvalid <= 1'b0;
                if (w != 0 && queued_items.size() != 0) w--;
            end
            send_delay <= w;
        end
    end

    // Sink side: random back-pressure, in-order compare against expected heights
    always @(posedge aclk) begin : monitor
        logic signed [HEIGHT_W-1:0] want;
        int unsigned                w;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            hold_delay <= draw_idle(take_calm);
        end else begin
            w = hold_delay;
            if (m_tvalid && m_tready) begin
                if (pending_heights.size() == 0) begin
                    flag($sformatf("height %0d with no query outstanding", $signed(m_tdata)));
                end else begin
                    want = pending_heights.pop_front();
                    if (m_tdata !== want)
                        flag($sformatf("height expected %0d (%h) got %0d (%h)",
                                       want, want, $signed(m_tdata), m_tdata));
                end
                w = draw_idle(take_calm);
            end
            if (w == 0) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b0;
                w--;
            end
            hold_delay <= w;
        end
    end

    // Watchdog: too long without a transaction on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        grid_cfg_t plan[9];
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed, reset registers (unit cells, origin 0): corner extremes and both triangles
        add_write(0, 0, 32'sh7FFF_FFFF);
        add_write(1, 0, 32'sh8000_0000);
        add_write(0, 1, 32'sh0000_0000);
        add_write(1, 1, 32'shFFFF_FFFF);
        add_write(255, 255, pick_height());
        add_write(254, 255, pick_height());
        add_write(255, 254, pick_height());
        add_write(254, 254, pick_height());
        add_query(32'sh0000_0000, 32'sh0000_0000);     // exact grid point
        add_query(32'sh0000_C000, 32'sh0000_4000);     // tx > tz
        add_query(32'sh0000_4000, 32'sh0000_C000);     // tx < tz
        add_query(32'sh0000_8000, 32'sh0000_8000);     // on the diagonal
        add_query(32'sh0000_FFFF, 32'sh0000_FFFF);     // largest fraction
        add_query(32'shFFFF_FFFF, 32'sh8000_0000);     // below origin on both axes
        add_query(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);     // clamped to the far corner
        add_query(32'sh7FFF_FFFF, 32'sh0000_0000);     // clamped in x only
        add_query(32'sh0001_0000, 32'sh0000_0000);

        plan[0] = grid_setting(32'h0, 32'h0, 65536, 4, 4);
        plan[1] = grid_setting(32'h8000_0000, 32'h7FFF_FFFF, 6554, 256, 2);
        plan[2] = grid_setting($urandom, $urandom, 0, 0, 1);           // zero reciprocal, tiny counts
        plan[3] = grid_setting(32'($urandom_range(0, 1 << 20)) - 32'(1 << 19),
                               32'($urandom_range(0, 1 << 20)) - 32'(1 << 19),
                               131071, 511, 300);                      // counts above the store
        plan[4] = grid_setting(-(32'sd3 << 16), 32'sd5 << 16, 32768, 2, 256);
        for (int i = 5; i < 9; i++)
            plan[i] = grid_setting($urandom, $urandom, $urandom_range(6554, 65536),
                                   $urandom_range(2, 12), $urandom_range(2, 12));
        plan[7].cols = 256;

        for (int p = 0; p < 9; p++) begin
            settle();
            program_grid(plan[p]);
            fill_phase(PHASE_ITEMS);
        end
        settle();

        if (error_count == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/hts_pkg.sv
src/hts_grid.sv
src/heightfield_triangle_sampler_top.sv
bench/tb_heightfield_triangle_sampler_top.sv
